// File: rtl/scfr_pkg.sv
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared types and constants of the sync/CRC frame receiver.
// ----------------------------------------------------------------------------
package scfr_pkg;

    // window depth must stay a power of two: window positions wrap by truncation
    localparam int WINDOW_DEPTH = 64;
    localparam int MAX_PAYLOAD  = 48;

    localparam int WIN_AW = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int LEN_W  = 6;

    localparam logic [7:0]  SYNC_BYTE0 = 8'hA5;
    localparam logic [7:0]  SYNC_BYTE1 = 8'h5A;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_VERSION = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_LEN  = 8'd1;

    localparam logic [7:0]       PROTO_VER_RST = 8'd1;
    localparam logic [LEN_W-1:0] MAX_LEN_RST   = 6'd48;

    // command from the sequencer to the crc unit
    typedef struct packed {
        logic       init;
        logic       update;
        logic [7:0] data;
    } crc_cmd_t;

endpackage

// File: rtl/sync_crc_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// sync_crc_frame_receiver_unit
// Byte-stream frame parser: A5 5A sync, header, length, CRC-16/CCITT-FALSE.
// ----------------------------------------------------------------------------
// Each received byte goes into a 64-byte circular window. After the byte is
// stored, a small sequencer reads the window through a single memory read
// port: it strips leading bytes until the window starts with A5 5A, then
// reads version through CRC, feeding version through payload into a
// byte-wide CRC unit, and on a good frame presents one result per payload
// byte (one header-only result for an empty payload). s_tready is low until
// the sequencer is back to idle. The last result of a frame may still wait
// in the output register while the next byte is taken. Configuration writes
// are always accepted.
// ----------------------------------------------------------------------------
module sync_crc_frame_receiver_unit
    import scfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // [15:0] sequence_number, [21:16] payload_length,
                                            // [29:22] payload_byte, [35:30] byte_index, [39:36] 0
    output logic [7:0]           m_tuser,   // [7:0] frame_type
    output logic                 m_tlast,   // last_of_frame
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SYNC,
        S_SYNC_B0,
        S_SYNC_B1,
        S_SCAN,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    state_t state_reg, state_next;

    logic [WIN_AW-1:0] head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        b0_reg, b0_next;
    logic [FILL_W-1:0] rpos_reg, rpos_next;
    logic [FILL_W-1:0] dpos_reg, dpos_next;
    logic [7:0]        ver_reg, ver_next;
    logic [7:0]        type_reg, type_next;
    logic [15:0]       seq_reg, seq_next;
    logic [7:0]        lenlo_reg, lenlo_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [7:0]        crclo_reg, crclo_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;

    logic              ovalid_reg, ovalid_next;
    logic [7:0]        otype_reg, otype_next;
    logic [15:0]       oseq_reg, oseq_next;
    logic [LEN_W-1:0]  olen_reg, olen_next;
    logic [7:0]        obyte_reg, obyte_next;
    logic [LEN_W-1:0]  oidx_reg, oidx_next;
    logic              olast_reg, olast_next;

    logic [7:0]        proto_ver_reg, proto_ver_next;
    logic [LEN_W-1:0]  max_len_reg, max_len_next;

    logic              ram_we;
    logic [WIN_AW-1:0] ram_waddr;
    logic              ram_re;
    logic [FILL_W-1:0] rd_pos;
    logic [WIN_AW-1:0] ram_raddr;
    logic [7:0]        mem_q;

    crc_cmd_t          crc_cmd;
    logic [15:0]       crc_val;

    logic              in_acc;
    logic              out_free;
    logic [7:0]        limit;
    logic [FILL_W-1:0] pay_end;
    logic [FILL_W-1:0] frame_total;
    logic [FILL_W-1:0] need_fill;
    logic              last_res;

    scfr_win_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (mem_q)
    );

    scfr_crc_unit u_crc (
        .aclk (aclk),
        .cmd  (crc_cmd),
        .crc  (crc_val)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !ovalid_reg || m_tready;
    assign ram_raddr = head_reg + rd_pos[WIN_AW-1:0];

    assign limit = ({2'b00, max_len_reg} < 8'(MAX_PAYLOAD)) ? {2'b00, max_len_reg}
                                                            : 8'(MAX_PAYLOAD);
    assign pay_end     = FILL_W'(8) + FILL_W'(len_reg);
    assign frame_total = FILL_W'(10) + FILL_W'(len_reg);
    assign need_fill   = FILL_W'(10) + FILL_W'(lenlo_reg[LEN_W-1:0]);
    assign last_res    = (len_reg == '0) || (idx_reg == len_reg - LEN_W'(1));

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        b0_next        = b0_reg;
        rpos_next      = rpos_reg;
        dpos_next      = dpos_reg;
        ver_next       = ver_reg;
        type_next      = type_reg;
        seq_next       = seq_reg;
        lenlo_next     = lenlo_reg;
        len_next       = len_reg;
        crclo_next     = crclo_reg;
        idx_next       = idx_reg;
        ovalid_next    = ovalid_reg && !m_tready;
        otype_next     = otype_reg;
        oseq_next      = oseq_reg;
        olen_next      = olen_reg;
        obyte_next     = obyte_reg;
        oidx_next      = oidx_reg;
        olast_next     = olast_reg;
        proto_ver_next = proto_ver_reg;
        max_len_next   = max_len_reg;
        ram_we         = 1'b0;
        ram_waddr      = head_reg + fill_reg[WIN_AW-1:0];
        ram_re         = 1'b0;
        rd_pos         = '0;
        crc_cmd        = '{init: 1'b0, update: 1'b0, data: mem_q};

        if (cfg_valid) begin
            if (cfg_index == CFG_PROTOCOL_VERSION) begin
                proto_ver_next = cfg_data;
            end else if (cfg_index == CFG_MAX_PAYLOAD_LEN) begin
                max_len_next = cfg_data[LEN_W-1:0];
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    ram_we = 1'b1;
                    // full window: the new byte overwrites the oldest one
                    if (fill_reg == FILL_W'(WINDOW_DEPTH)) begin
                        head_next = head_reg + WIN_AW'(1);
                    end else begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    state_next = S_SYNC;
                end
            end
            S_SYNC: begin
                if (fill_reg < FILL_W'(2)) begin
                    state_next = S_IDLE;
                end else begin
                    ram_re     = 1'b1;
                    rd_pos     = FILL_W'(0);
                    state_next = S_SYNC_B0;
                end
            end
            S_SYNC_B0: begin
                b0_next    = mem_q;
                ram_re     = 1'b1;
                rd_pos     = FILL_W'(1);
                state_next = S_SYNC_B1;
            end
            S_SYNC_B1: begin
                // position 2 is either the next header byte or the new second byte
                ram_re    = 1'b1;
                rd_pos    = FILL_W'(2);
                rpos_next = FILL_W'(3);
                dpos_next = FILL_W'(2);
                if (b0_reg == SYNC_BYTE0 && mem_q == SYNC_BYTE1) begin
                    if (fill_reg < FILL_W'(8)) begin
                        state_next = S_IDLE;
                    end else begin
                        crc_cmd.init = 1'b1;
                        state_next   = S_SCAN;
                    end
                end else begin
                    head_next = head_reg + WIN_AW'(1);
                    fill_next = fill_reg - FILL_W'(1);
                    b0_next   = mem_q;
                    if (fill_reg < FILL_W'(3)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                ram_re    = 1'b1;
                rd_pos    = rpos_reg;
                rpos_next = rpos_reg + FILL_W'(1);
                dpos_next = dpos_reg + FILL_W'(1);
                crc_cmd.update = (dpos_reg < pay_end);
                if (dpos_reg < FILL_W'(8)) begin
                    case (dpos_reg[2:0])
                        3'd2:    ver_next = mem_q;
                        3'd3:    type_next = mem_q;
                        3'd4:    seq_next[7:0] = mem_q;
                        3'd5:    seq_next[15:8] = mem_q;
                        3'd6:    lenlo_next = mem_q;
                        3'd7: begin
                            len_next = lenlo_reg[LEN_W-1:0];
                            if (ver_reg != proto_ver_reg || mem_q != 8'd0 ||
                                lenlo_reg > limit) begin
                                head_next  = head_reg + WIN_AW'(1);
                                fill_next  = fill_reg - FILL_W'(1);
                                state_next = S_IDLE;
                            end else if (fill_reg < need_fill) begin
                                state_next = S_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end else if (dpos_reg == pay_end) begin
                    crclo_next = mem_q;
                end else if (dpos_reg == pay_end + FILL_W'(1)) begin
                    idx_next = '0;
                    if (crc_val != {mem_q, crclo_reg}) begin
                        head_next  = head_reg + WIN_AW'(1);
                        fill_next  = fill_reg - FILL_W'(1);
                        state_next = S_IDLE;
                    end else if (len_reg == '0) begin
                        state_next = S_EMIT_LD;
                    end else begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_EMIT_RD: begin
                ram_re     = 1'b1;
                rd_pos     = FILL_W'(8) + FILL_W'(idx_reg);
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    otype_next  = type_reg;
                    oseq_next   = seq_reg;
                    olen_next   = len_reg;
                    obyte_next  = (len_reg == '0) ? 8'd0 : mem_q;
                    oidx_next   = idx_reg;
                    olast_next  = last_res;
                    if (last_res) begin
                        head_next  = head_reg + frame_total[WIN_AW-1:0];
                        fill_next  = fill_reg - frame_total;
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + LEN_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            ovalid_reg    <= 1'b0;
            proto_ver_reg <= PROTO_VER_RST;
            max_len_reg   <= MAX_LEN_RST;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            ovalid_reg    <= ovalid_next;
            proto_ver_reg <= proto_ver_next;
            max_len_reg   <= max_len_next;
        end
        b0_reg    <= b0_next;
        rpos_reg  <= rpos_next;
        dpos_reg  <= dpos_next;
        ver_reg   <= ver_next;
        type_reg  <= type_next;
        seq_reg   <= seq_next;
        lenlo_reg <= lenlo_next;
        len_reg   <= len_next;
        crclo_reg <= crclo_next;
        idx_reg   <= idx_next;
        otype_reg <= otype_next;
        oseq_reg  <= oseq_next;
        olen_reg  <= olen_next;
        obyte_reg <= obyte_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {4'b0000, oidx_reg, obyte_reg, olen_reg, oseq_reg};
    assign m_tuser  = otype_reg;
    assign m_tlast  = olast_reg;

endmodule

// File: rtl/scfr_win_ram.sv
// ----------------------------------------------------------------------------
// scfr_win_ram
// Byte window storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module scfr_win_ram
    import scfr_pkg::*;
(
    input  logic              aclk,
    input  logic              we,
    input  logic [WIN_AW-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [WIN_AW-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [WINDOW_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/scfr_crc_unit.sv
// ----------------------------------------------------------------------------
// scfr_crc_unit
// CRC-16/CCITT-FALSE accumulator, one byte per cycle, MSB first.
// ----------------------------------------------------------------------------
module scfr_crc_unit
    import scfr_pkg::*;
(
    input  logic        aclk,
    input  crc_cmd_t    cmd,
    output logic [15:0] crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
        logic [15:0] c;
        c = c_in ^ {d, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    always_comb begin
        crc_next = crc_reg;
        if (cmd.init) begin
            crc_next = CRC_INIT;
        end else if (cmd.update) begin
            crc_next = crc_byte(crc_reg, cmd.data);
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

// File: rtl/scfr_checker.sv
// ----------------------------------------------------------------------------
// scfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module scfr_checker
    import scfr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [7:0]  m_tuser,
    input logic        m_tlast
);

    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] bidx;
    logic [7:0]       pbyte;

    assign plen  = m_tdata[21:16];
    assign pbyte = m_tdata[29:22];
    assign bidx  = m_tdata[35:30];

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // one item at a time: no back-to-back accepts
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous item in work");

    // the frame closes on its last payload byte
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (plen == '0 && bidx == '0) ||
                                (plen != '0 && bidx == plen - LEN_W'(1)))
        else $error("last marker on wrong byte");

    a_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> plen != '0 && bidx < plen - LEN_W'(1))
        else $error("byte index beyond payload");

    // header-only result carries a zero byte
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && plen == '0 |-> pbyte == 8'd0 && m_tlast)
        else $error("bad header-only result");

endmodule

bind sync_crc_frame_receiver_unit scfr_checker u_scfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: sim/sync_crc_frame_receiver_checker.sv
// ----------------------------------------------------------------------------
// sync_crc_frame_receiver_checker
// Watches the byte, result and register channels of the frame receiver,
// keeps its own copy of the receive window and the registers, works out the
// payload items each accepted byte releases and compares them in order.
// ----------------------------------------------------------------------------
module sync_crc_frame_receiver_checker
    import scfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [39:0]          m_tdata,   // [15:0] sequence_number, [21:16] payload_length,
                                            // [29:22] payload_byte, [35:30] byte_index, [39:36] 0
    input  logic [7:0]           m_tuser,   // [7:0] frame_type
    input  logic                 m_tlast,   // last_of_frame
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]       ftype;
        logic [15:0]      seq;
        logic [LEN_W-1:0] plen;
        logic [7:0]       pbyte;
        logic [LEN_W-1:0] idx;
        logic             last;
    } payload_item_t;

    logic [7:0]       rx_window[$];
    payload_item_t    payload_q[$];
    logic [7:0]       accept_version;
    logic [LEN_W-1:0] accept_max_len;
    int               mismatches;

    // crc over window bytes from the version byte on
    function automatic logic [15:0] window_crc(input int n);
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i < n; i++) begin
            c = c ^ {rx_window[2 + i], 8'h00};
            for (int b = 0; b < 8; b++) begin
                if (c[15]) begin
                    c = (c << 1) ^ CRC_POLY;
                end else begin
                    c = c << 1;
                end
            end
        end
        return c;
    endfunction

    task automatic take_byte(input logic [7:0] rx);
        int            len;
        int            limit;
        int            total;
        int            count;
        logic [15:0]   sent_crc;
        payload_item_t item;
        if (rx_window.size() >= WINDOW_DEPTH) begin
            rx_window.delete(0);
        end
        rx_window.push_back(rx);
        while (rx_window.size() >= 2 &&
               !(rx_window[0] == SYNC_BYTE0 && rx_window[1] == SYNC_BYTE1)) begin
            rx_window.delete(0);
        end
        if (rx_window.size() < 8) begin
            return;
        end
        len   = {rx_window[7], rx_window[6]};
        limit = (accept_max_len < MAX_PAYLOAD) ? accept_max_len : MAX_PAYLOAD;
        if (rx_window[2] != accept_version || len > limit) begin
            rx_window.delete(0);
            return;
        end
        total = 10 + len;
        if (rx_window.size() < total) begin
            return;
        end
        sent_crc = {rx_window[9 + len], rx_window[8 + len]};
        if (window_crc(6 + len) != sent_crc) begin
            rx_window.delete(0);
            return;
        end
        // empty payload still gives one header-only item
        count = (len == 0) ? 1 : len;
        for (int i = 0; i < count; i++) begin
            item.ftype = rx_window[3];
            item.seq   = {rx_window[5], rx_window[4]};
            item.plen  = len[LEN_W-1:0];
            item.pbyte = (len == 0) ? 8'h00 : rx_window[8 + i];
            item.idx   = i[LEN_W-1:0];
            item.last  = (i == count - 1);
            payload_q.push_back(item);
        end
        repeat (total) rx_window.delete(0);
    endtask

    function automatic bit field_ok(input string name, input int want, input int seen);
        if (want != seen) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, seen);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        payload_item_t want;
        payload_item_t seen;
        bit            ok;
        if (!aresetn) begin
            rx_window.delete();
            payload_q.delete();
            accept_version = PROTO_VER_RST;
            accept_max_len = MAX_LEN_RST;
            pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.ftype = m_tuser;
                seen.seq   = m_tdata[15:0];
                seen.plen  = m_tdata[21:16];
                seen.pbyte = m_tdata[29:22];
                seen.idx   = m_tdata[35:30];
                seen.last  = m_tlast;
                if (payload_q.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %h", $time, seen);
                    mismatches++;
                end else begin
                    want = payload_q.pop_front();
                    ok = 1'b1;
                    ok &= field_ok("frame_type", want.ftype, seen.ftype);
                    ok &= field_ok("sequence_number", want.seq, seen.seq);
                    ok &= field_ok("payload_length", want.plen, seen.plen);
                    ok &= field_ok("payload_byte", want.pbyte, seen.pbyte);
                    ok &= field_ok("byte_index", want.idx, seen.idx);
                    ok &= field_ok("last_of_frame", want.last, seen.last);
                    if (!ok) begin
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_PROTOCOL_VERSION) begin
                    accept_version = cfg_data;
                end else if (cfg_index == CFG_MAX_PAYLOAD_LEN) begin
                    accept_max_len = cfg_data[LEN_W-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                take_byte(s_tdata);
            end
            pending <= payload_q.size();
        end
        fail_count <= mismatches;
    end

endmodule

// File: sim/sync_crc_frame_receiver_unit_tb.sv
// ----------------------------------------------------------------------------
// sync_crc_frame_receiver_unit_tb
// Feeds the frame receiver with good, damaged and cut-off frames mixed with
// line noise, under several register settings and stall patterns; the
// checker beside the block predicts and compares every payload item.
// ----------------------------------------------------------------------------
module sync_crc_frame_receiver_unit_tb;
    import scfr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 400;
    localparam int RUN_LIMIT_NS  = 5_000_000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;   // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [39:0]          m_tdata;   // [15:0] sequence_number, [21:16] payload_length,
                                     // [29:22] payload_byte, [35:30] byte_index, [39:36] 0
    logic [7:0]           m_tuser;   // [7:0] frame_type
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = 8'h00;
    int                   fail_count;
    int                   pending;

    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    logic [7:0] link_version = PROTO_VER_RST;
    int         link_limit   = MAX_PAYLOAD;
    logic [7:0] burst[$];

    sync_crc_frame_receiver_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sync_crc_frame_receiver_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // crc of burst bytes, used only to build frames on the link side
    function automatic logic [15:0] burst_crc(input int first, input int n);
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i < n; i++) begin
            c = c ^ {burst[first + i], 8'h00};
            for (int b = 0; b < 8; b++) begin
                if (c[15]) begin
                    c = (c << 1) ^ CRC_POLY;
                end else begin
                    c = c << 1;
                end
            end
        end
        return c;
    endfunction

    // appends one frame; payload_fill below zero means random payload bytes
    task automatic build_frame(input logic [7:0] ver, input logic [7:0] ftype,
                               input logic [15:0] seq, input logic [15:0] len_field,
                               input int n_payload, input int payload_fill,
                               input bit bad_crc);
        int          first;
        logic [15:0] crc;
        first = burst.size();
        burst.push_back(SYNC_BYTE0);
        burst.push_back(SYNC_BYTE1);
        burst.push_back(ver);
        burst.push_back(ftype);
        burst.push_back(seq[7:0]);
        burst.push_back(seq[15:8]);
        burst.push_back(len_field[7:0]);
        burst.push_back(len_field[15:8]);
        for (int i = 0; i < n_payload; i++) begin
            burst.push_back((payload_fill < 0) ? 8'($urandom) : 8'(payload_fill));
        end
        crc = burst_crc(first + 2, 6 + n_payload);
        if (bad_crc) begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
        end
        burst.push_back(crc[7:0]);
        burst.push_back(crc[15:8]);
    endtask

    task automatic send_byte(input logic [7:0] rx);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_burst();
        foreach (burst[i]) begin
            send_byte(burst[i]);
        end
        burst.delete();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_config(input logic [7:0] ver, input logic [7:0] max_len,
                              input bit stray_write);
        write_reg(CFG_PROTOCOL_VERSION, ver);
        write_reg(CFG_MAX_PAYLOAD_LEN, max_len);
        // an index past the register list must leave both registers alone
        if (stray_write) begin
            write_reg(CFG_IDX_W'($urandom_range(2, 255)), 8'($urandom));
        end
        cfg_valid <= 1'b0;
        link_version = ver;
        link_limit   = (max_len[LEN_W-1:0] < MAX_PAYLOAD) ? max_len[LEN_W-1:0] : MAX_PAYLOAD;
    endtask

    // lets the block finish its work so registers may be rewritten
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic int pick_len();
        int roll;
        roll = $urandom_range(99);
        if (link_limit == 0) begin
            return 0;
        end else if (roll < 6) begin
            return link_limit;
        end else if (roll < 88) begin
            return $urandom_range((link_limit < 8) ? link_limit : 8);
        end
        return $urandom_range(link_limit);
    endfunction

    task automatic random_traffic(input int n_bytes);
        int          sent;
        int          roll;
        int          len;
        int          keep;
        int          first;
        logic [15:0] big_len;
        sent = 0;
        while (sent < n_bytes) begin
            roll = $urandom_range(99);
            len  = pick_len();
            if (roll < 60) begin
                build_frame(link_version, 8'($urandom), 16'($urandom), 16'(len), len, -1, 1'b0);
            end else if (roll < 68) begin
                build_frame(link_version ^ 8'($urandom_range(1, 255)), 8'($urandom),
                            16'($urandom), 16'(len), len, -1, 1'b0);
            end else if (roll < 75) begin
                // oversize length, either past the limit up to 63 or a nonzero high byte
                if (link_limit < 63 && $urandom_range(1)) begin
                    big_len = 16'($urandom_range(link_limit + 1, 63));
                end else begin
                    big_len = {8'($urandom_range(1, 255)), 8'($urandom)};
                end
                build_frame(link_version, 8'($urandom), 16'($urandom), big_len,
                            $urandom_range(4), -1, 1'b0);
            end else if (roll < 85) begin
                build_frame(link_version, 8'($urandom), 16'($urandom), 16'(len), len, -1, 1'b1);
            end else if (roll < 91) begin
                // frame cut short, the following bytes land inside it
                first = burst.size();
                build_frame(link_version, 8'($urandom), 16'($urandom), 16'(len), len, -1, 1'b0);
                keep = $urandom_range(3, 9 + len);
                while (burst.size() > first + keep) begin
                    void'(burst.pop_back());
                end
            end else begin
                repeat ($urandom_range(1, 6)) burst.push_back(8'($urandom));
                if ($urandom_range(2) == 0) begin
                    burst.push_back(SYNC_BYTE0);
                    if ($urandom_range(1)) begin
                        burst.push_back(SYNC_BYTE1);
                    end
                end
            end
            sent += burst.size();
            send_burst();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 35;
        rx_idle_pct = 71;
        set_config(8'h00, 8'd48, 1'b0);
        // leading junk and a lone sync byte, then an empty and a one-byte frame
        burst.push_back(8'h00);
        burst.push_back(SYNC_BYTE0);
        build_frame(link_version, 8'hFF, 16'hFFFF, 16'd0, 0, -1, 1'b0);
        build_frame(link_version, 8'h00, 16'h0000, 16'd1, 1, 8'hFF, 1'b0);
        send_burst();
        random_traffic(110);
        drain();

        // only header-only frames fit
        set_config(8'hFF, 8'd0, 1'b1);
        random_traffic(80);
        drain();

        tx_idle_pct = 71;
        rx_idle_pct = 35;
        // value wider than the length register, limit stays at the parameter
        set_config(8'($urandom), 8'hFF, 1'b1);
        random_traffic(140);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(PROTO_VER_RST, 8'($urandom_range(4, 12)), 1'b0);
        random_traffic(140);
        drain();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
